// ===== hdl/bpfm_pkg.sv =====
`timescale 1ns / 1ps

package bpfm_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgIndexWidth = 1;

  localparam logic [CountWidth-1:0] DelayReset = CountWidth'(100);
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [CfgIndexWidth-1:0] CFG_INPUT_DELAY = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_LATCH_DELAY = 1'b1;

  typedef struct packed {
    logic enable;
    logic active;
  } cnt_ctrl_t;

endpackage

// ===== hdl/bpfm_counter.sv =====
`timescale 1ns / 1ps

module bpfm_counter import bpfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cnt_ctrl_t             ctrl,
  input  logic [CountWidth-1:0] delay,
  output logic                  trip
);

  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic [CountWidth:0]   advanced;
  logic [CountWidth-1:0] saturated;

  always_comb begin
    if (count <= delay) begin
      advanced = {1'b0, count} + (CountWidth+1)'(1);
    end else begin
      advanced = {1'b0, delay} + (CountWidth+1)'(1);
    end
    saturated = advanced[CountWidth] ? CountMax : advanced[CountWidth-1:0];
    count_next = ctrl.active ? saturated : '0;
    trip = ctrl.active && (saturated > delay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.enable) begin
      count <= count_next;
    end
  end

endmodule

// ===== hdl/brake_plausibility_fault_monitor.sv =====
`timescale 1ns / 1ps

// Brake plausibility fault monitor. One tick of three fault pins is taken per
// transfer, and a new tick can be taken in every cycle without an input stall.
// The result of a tick appears in the output register in the cycle after its
// transfer; the only work between the two is one increment and compare per
// fault counter. The block stalls its input only while the output register
// holds a result that the sink stalls. The overall fault stays latched until
// reset. The user must write delays via the configuration port while idle; unenforced.
module brake_plausibility_fault_monitor import bpfm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CountWidth-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     brake_sensor_pin,
  input  logic                     current_sensor_pin,
  input  logic                     hard_brake_power_pin,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     brake_sensor_tripped,
  output logic                     current_sensor_tripped,
  output logic                     hard_brake_power_tripped,
  output logic                     input_tripped,
  output logic                     overall_latched
);

  logic [CountWidth-1:0] input_delay;
  logic [CountWidth-1:0] latch_delay;
  logic                  overall_flag;
  logic                  overall_flag_next;
  logic                  accept;
  logic                  brake_trip;
  logic                  current_trip;
  logic                  braking_trip;
  logic                  latch_trip;
  cnt_ctrl_t             brake_ctrl;
  cnt_ctrl_t             current_ctrl;
  cnt_ctrl_t             braking_ctrl;
  cnt_ctrl_t             latch_ctrl;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_delay <= DelayReset;
      latch_delay <= DelayReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_INPUT_DELAY: input_delay <= cfg_data;
        CFG_LATCH_DELAY: latch_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  assign brake_ctrl = '{enable: accept, active: !brake_sensor_pin};
  assign current_ctrl = '{enable: accept, active: !current_sensor_pin};
  assign braking_ctrl = '{enable: accept, active: hard_brake_power_pin};
  assign latch_ctrl = '{enable: accept && !overall_flag,
                        active: brake_trip || current_trip || braking_trip};

  bpfm_counter u_brake (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (brake_ctrl),
    .delay (input_delay),
    .trip  (brake_trip)
  );

  bpfm_counter u_current (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (current_ctrl),
    .delay (input_delay),
    .trip  (current_trip)
  );

  bpfm_counter u_braking (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (braking_ctrl),
    .delay (input_delay),
    .trip  (braking_trip)
  );

  bpfm_counter u_latch (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (latch_ctrl),
    .delay (latch_delay),
    .trip  (latch_trip)
  );

  assign overall_flag_next = overall_flag || (latch_ctrl.enable && latch_trip);

  always_ff @(posedge clk) begin
    if (rst) begin
      overall_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      overall_flag <= overall_flag_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      brake_sensor_tripped <= brake_trip;
      current_sensor_tripped <= current_trip;
      hard_brake_power_tripped <= braking_trip;
      input_tripped <= brake_trip || current_trip;
      overall_latched <= overall_flag_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) overall_flag |=> overall_flag)
    else $error("Overall fault flag cleared without reset.");

  assert property (@(posedge clk) disable iff (rst)
    accept && brake_sensor_pin |=> !brake_sensor_tripped)
    else $error("Brake sensor tripped on an inactive pin.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && overall_latched |-> overall_flag)
    else $error("Reported latch does not match the flag.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && !accept |=> out_valid && $stable(overall_latched))
    else $error("Stalled result was lost or changed.");

endmodule

// ===== bench/brake_plausibility_fault_monitor_test.sv =====
`timescale 1ns / 1ps

module brake_plausibility_fault_monitor_test;
  import bpfm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic brake_trip;
    logic current_trip;
    logic power_trip;
    logic input_trip;
    logic latched;
  } fault_status_t;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_t;

  class fault_status_predictor;
    logic [CountWidth-1:0] input_delay;
    logic [CountWidth-1:0] latch_delay;
    logic [CountWidth-1:0] brake_count;
    logic [CountWidth-1:0] current_count;
    logic [CountWidth-1:0] power_count;
    logic [CountWidth-1:0] latch_count;
    logic latched;
    fault_status_t expected_status[$];
    int unsigned mismatches;

    function new();
      input_delay = DelayReset;
      latch_delay = DelayReset;
      brake_count = '0;
      current_count = '0;
      power_count = '0;
      latch_count = '0;
      latched = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CfgIndexWidth-1:0] index, logic [CountWidth-1:0] value);
      if (index == CFG_INPUT_DELAY) begin
        input_delay = value;
      end else if (index == CFG_LATCH_DELAY) begin
        latch_delay = value;
      end
    endfunction

    // A counter above its delay snaps back to delay + 1, and never wraps.
    function logic [CountWidth-1:0] advance(logic [CountWidth-1:0] count,
                                            logic [CountWidth-1:0] delay);
      logic [CountWidth:0] next;
      next = {1'b0, (count <= delay) ? count : delay} + 1'b1;
      if (next > {1'b0, CountMax}) begin
        next = {1'b0, CountMax};
      end
      return next[CountWidth-1:0];
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void note_tick(logic brake_pin, logic current_pin, logic power_pin);
      fault_status_t status;
      brake_count = brake_pin ? '0 : advance(brake_count, input_delay);
      current_count = current_pin ? '0 : advance(current_count, input_delay);
      power_count = power_pin ? advance(power_count, input_delay) : '0;
      status.brake_trip = brake_count > input_delay;
      status.current_trip = current_count > input_delay;
      status.power_trip = power_count > input_delay;
      status.input_trip = status.brake_trip || status.current_trip;
      if (!latched) begin
        if (status.input_trip || status.power_trip) begin
          latch_count = advance(latch_count, latch_delay);
          latched = latch_count > latch_delay;
        end else begin
          latch_count = '0;
        end
      end
      status.latched = latched;
      expected_status.push_back(status);
    endfunction

    function void check_status(fault_status_t actual);
      fault_status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("[%0t] result %b arrived with no tick pending", $realtime, actual);
        end
      end else begin
        want = expected_status.pop_front();
        if (actual !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("[%0t] expected brake=%b current=%b power=%b input=%b latched=%b",
                     $realtime, want.brake_trip, want.current_trip, want.power_trip,
                     want.input_trip, want.latched);
            $display("[%0t] actual   brake=%b current=%b power=%b input=%b latched=%b",
                     $realtime, actual.brake_trip, actual.current_trip, actual.power_trip,
                     actual.input_trip, actual.latched);
          end
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CountWidth-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     brake_sensor_pin;
  logic                     current_sensor_pin;
  logic                     hard_brake_power_pin;
  logic                     out_valid;
  logic                     out_stall;
  logic                     brake_sensor_tripped;
  logic                     current_sensor_tripped;
  logic                     hard_brake_power_tripped;
  logic                     input_tripped;
  logic                     overall_latched;

  fault_status_predictor fault_predictor;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  logic [2:0] pin_level;
  int unsigned run_left[3];
  stall_mode_t stall_mode = StallNone;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;

  brake_plausibility_fault_monitor dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // A transfer's expectation is noted before the output is checked, so the
  // order holds for any latency of the block.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        fault_predictor.note_tick(brake_sensor_pin, current_sensor_pin, hard_brake_power_pin);
      end
      if (out_valid && !out_stall) begin
        fault_predictor.check_status(fault_status_t'({brake_sensor_tripped,
                                                      current_sensor_tripped,
                                                      hard_brake_power_tripped,
                                                      input_tripped, overall_latched}));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      StallNone: out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_phase % 5) < 2);
    endcase
  end

  task automatic send_tick(input logic brake_pin, input logic current_pin,
                           input logic power_pin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    brake_sensor_pin <= brake_pin;
    current_sensor_pin <= current_pin;
    hard_brake_power_pin <= power_pin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Each pin holds its level for a run of random length, so faults can persist
  // long enough to trip at small input delays; some ticks are plain noise.
  task automatic random_tick(input int unsigned span);
    logic [2:0] pins;
    if ($urandom_range(0, 99) < 15) begin
      pins = 3'($urandom_range(0, 7));
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (run_left[k] == 0) begin
          pin_level[k] = 1'($urandom_range(0, 1));
          run_left[k] = $urandom_range(1, span);
        end
        run_left[k]--;
      end
      pins = pin_level;
    end
    send_tick(pins[2], pins[1], pins[0]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (fault_predictor.pending() != 0) @(negedge clk);
  endtask

  task automatic set_delays(input logic [CountWidth-1:0] input_delay,
                            input logic [CountWidth-1:0] latch_delay);
    cfg_write <= 1'b1;
    cfg_index <= CFG_INPUT_DELAY;
    cfg_data <= input_delay;
    fault_predictor.set_register(CFG_INPUT_DELAY, input_delay);
    @(negedge clk);
    cfg_index <= CFG_LATCH_DELAY;
    cfg_data <= latch_delay;
    fault_predictor.set_register(CFG_LATCH_DELAY, latch_delay);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned phase_input[6];
    int unsigned phase_latch[6];
    int unsigned phase_items[6];
    int unsigned span;
    fault_predictor = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_INPUT_DELAY;
    cfg_data = '0;
    in_valid = 1'b0;
    brake_sensor_pin = 1'b1;
    current_sensor_pin = 1'b1;
    hard_brake_power_pin = 1'b0;
    burst_left = 0;
    pin_level = 3'b110;
    for (int k = 0; k < 3; k++) begin
      run_left[k] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 8; i++) begin
      send_tick(i[2], i[1], i[0]);
    end

    // With no input delay an active fault trips on its first tick.
    wait_idle();
    set_delays(16'd0, 16'd65534);
    repeat (3) send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);

    // At the largest delay the counters stop short of tripping; lowering the
    // delay afterwards makes them trip on the next active tick.
    wait_idle();
    set_delays(CountMax, 16'd65534);
    repeat (4) send_tick(1'b0, 1'b0, 1'b1);
    wait_idle();
    set_delays(16'd2, 16'd65534);
    repeat (2) send_tick(1'b0, 1'b0, 1'b1);

    phase_input = '{2, 0, $urandom_range(3, 12), 65534, 1, $urandom_range(0, 4)};
    phase_latch = '{65534, $urandom_range(20, 60), $urandom_range(15, 40),
                    $urandom_range(1, 5), $urandom_range(5, 15), 0};
    phase_items = '{130, 100, 130, 60, 150, 180};
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      set_delays(phase_input[p][CountWidth-1:0], phase_latch[p][CountWidth-1:0]);
      span = 2 * (((phase_input[p] < 20) ? phase_input[p] : 20) + 2);
      repeat (phase_items[p]) random_tick(span);
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (fault_predictor.mismatches == 0 && fault_predictor.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
